// ===== design/bres_pkg.sv =====
package bres_pkg;

	typedef enum logic {
		CMD_START   = 1'b0,
		CMD_ADVANCE = 1'b1
	} cmd_t;

	localparam int QUEUE_DEPTH    = 4;
	localparam int QUEUE_PTR_BITS = 2;

endpackage

// ===== design/bresenham_line_rasterizer.sv =====
// channel  | handshake             | payload
// ---------+-----------------------+-------------------------------------
// request  | req_valid / req_stall | cmd, x_start, y_start, x_end, y_end
// pixel    | pix_valid / pix_stall | pixel_x, pixel_y, last
//
// Without stalls, one request per cycle, one pixel per cycle on back-to-back advances;
// the per-pixel error update in the back end is a single add and sign test.
// A request passes the front-stage register and the queue before the pixel register.
// Reset empties the front stage, the 4-entry queue and the pixel register; no line active.
// A pixel stall backs up the queue; req_stall rises once the queue and front stage are full.
module bresenham_line_rasterizer #(
	parameter int COORD_BITS = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  logic                  cmd,
	input  logic [COORD_BITS-1:0] x_start,
	input  logic [COORD_BITS-1:0] y_start,
	input  logic [COORD_BITS-1:0] x_end,
	input  logic [COORD_BITS-1:0] y_end,
	output logic                  pix_valid,
	input  logic                  pix_stall,
	output logic [COORD_BITS-1:0] pixel_x,
	output logic [COORD_BITS-1:0] pixel_y,
	output logic                  last
);

	localparam int ENTRY_BITS = 6 * COORD_BITS + 11;

	logic                  push, queue_full, pop, head_valid;
	logic [ENTRY_BITS-1:0] push_data, head_data;

	bres_front #(
		.COORD_BITS (COORD_BITS),
		.ENTRY_BITS (ENTRY_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.cmd        (cmd),
		.x_start    (x_start),
		.y_start    (y_start),
		.x_end      (x_end),
		.y_end      (y_end),
		.push       (push),
		.push_data  (push_data),
		.queue_full (queue_full)
	);

	bres_queue #(
		.ENTRY_BITS (ENTRY_BITS)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	bres_back #(
		.COORD_BITS (COORD_BITS),
		.ENTRY_BITS (ENTRY_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.last       (last)
	);

endmodule

// ===== design/bres_front.sv =====
module bres_front #(
	parameter int COORD_BITS = 10,
	parameter int ENTRY_BITS = 6 * COORD_BITS + 11
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  logic                  cmd,
	input  logic [COORD_BITS-1:0] x_start,
	input  logic [COORD_BITS-1:0] y_start,
	input  logic [COORD_BITS-1:0] x_end,
	input  logic [COORD_BITS-1:0] y_end,
	output logic                  push,
	output logic [ENTRY_BITS-1:0] push_data,
	input  logic                  queue_full
);

	localparam int N = COORD_BITS;
	localparam int E = COORD_BITS + 3;

	// stage 1: order endpoints, get deltas and y direction
	logic         swap;
	logic [N-1:0] xa, xb, ya, yb, dx, dy;
	logic         y_down;

	always_comb begin
		swap   = x_start > x_end;
		xa     = swap ? x_end : x_start;
		xb     = swap ? x_start : x_end;
		ya     = swap ? y_end : y_start;
		yb     = swap ? y_start : y_end;
		dx     = xb - xa;
		y_down = !(yb > ya);
		dy     = y_down ? (ya - yb) : (yb - ya);
	end

	logic         valid_s1;
	logic         cmd_s1;
	logic [N-1:0] xa_s1, ya_s1, dx_s1, dy_s1;
	logic         y_down_s1;
	logic         accept;

	assign req_stall = valid_s1 && queue_full;
	assign accept    = req_valid && !req_stall;
	assign push      = valid_s1 && !queue_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1    <= cmd;
			xa_s1     <= xa;
			ya_s1     <= ya;
			dx_s1     <= dx;
			dy_s1     <= dy;
			y_down_s1 <= y_down;
		end
	end

	// stage 2: major/minor axis, initial error, step constants
	logic         steep;
	logic [N-1:0] major, minor;
	logic [N:0]   major2, minor2, count;
	logic [E-1:0] err0, diff;

	always_comb begin
		steep  = dy_s1 > dx_s1;
		major  = steep ? dy_s1 : dx_s1;
		minor  = steep ? dx_s1 : dy_s1;
		major2 = {major, 1'b0};
		minor2 = {minor, 1'b0};
		err0   = {2'b00, minor2} - {3'b000, major};
		diff   = {2'b00, minor2} - {2'b00, major2};
		count  = {1'b0, major} + {{N{1'b0}}, 1'b1};
	end

	assign push_data = {cmd_s1, y_down_s1, steep, xa_s1, ya_s1, minor2, diff, err0, count};

endmodule

// ===== design/bres_queue.sv =====
module bres_queue #(
	parameter int ENTRY_BITS = 71
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic [ENTRY_BITS-1:0] push_data,
	output logic                  full,
	input  logic                  pop,
	output logic                  head_valid,
	output logic [ENTRY_BITS-1:0] head_data
);

	logic [ENTRY_BITS-1:0]               mem [bres_pkg::QUEUE_DEPTH];
	logic [bres_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [bres_pkg::QUEUE_PTR_BITS:0]   count_q;

	assign full       = count_q == (bres_pkg::QUEUE_PTR_BITS + 1)'(bres_pkg::QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_data  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/bres_back.sv =====
module bres_back #(
	parameter int COORD_BITS = 10,
	parameter int ENTRY_BITS = 6 * COORD_BITS + 11
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head_valid,
	input  logic [ENTRY_BITS-1:0] head_data,
	output logic                  pop,
	output logic                  pix_valid,
	input  logic                  pix_stall,
	output logic [COORD_BITS-1:0] pixel_x,
	output logic [COORD_BITS-1:0] pixel_y,
	output logic                  last
);

	localparam int N = COORD_BITS;
	localparam int E = COORD_BITS + 3;
	localparam logic [N-1:0] ONE = N'(1);

	logic         h_cmd, h_y_down, h_steep;
	logic [N-1:0] h_xa, h_ya;
	logic [N:0]   h_minor2, h_count;
	logic [E-1:0] h_diff, h_err0;

	assign {h_cmd, h_y_down, h_steep, h_xa, h_ya, h_minor2, h_diff, h_err0, h_count} = head_data;

	logic [N-1:0] cur_x_q, cur_y_q;
	logic [E-1:0] err_q, diff_q;
	logic [N:0]   minor2_q, count_q;
	logic         steep_q, y_down_q, active_q;
	logic         pix_valid_q;
	logic [N-1:0] pix_x_q, pix_y_q;
	logic         last_q;

	logic         is_start, out_free, emit;
	logic         err_pos;
	logic [N-1:0] y_step, next_x, next_y;
	logic [E-1:0] next_err;

	assign is_start = h_cmd == bres_pkg::CMD_START;
	assign out_free = !pix_valid_q || !pix_stall;
	assign pop      = head_valid && (is_start || !active_q || out_free);
	assign emit     = pop && !is_start && active_q;

	always_comb begin
		err_pos  = !err_q[E-1] && (err_q != '0);
		y_step   = y_down_q ? (cur_y_q - ONE) : (cur_y_q + ONE);
		if (steep_q) begin
			next_x = err_pos ? (cur_x_q + ONE) : cur_x_q;
			next_y = y_step;
		end else begin
			next_x = cur_x_q + ONE;
			next_y = err_pos ? y_step : cur_y_q;
		end
		next_err = err_q + (err_pos ? diff_q : {2'b00, minor2_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			pix_valid_q <= 1'b0;
		end else begin
			if (pop && is_start) begin
				active_q <= 1'b1;
			end else if (emit && count_q == {{N{1'b0}}, 1'b1}) begin
				active_q <= 1'b0;
			end
			if (emit) begin
				pix_valid_q <= 1'b1;
			end else if (!pix_stall) begin
				pix_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && is_start) begin
			cur_x_q  <= h_xa;
			cur_y_q  <= h_ya;
			err_q    <= h_err0;
			diff_q   <= h_diff;
			minor2_q <= h_minor2;
			count_q  <= h_count;
			steep_q  <= h_steep;
			y_down_q <= h_y_down;
		end else if (emit) begin
			cur_x_q <= next_x;
			cur_y_q <= next_y;
			err_q   <= next_err;
			count_q <= count_q - 1'b1;
		end
		if (emit) begin
			pix_x_q <= cur_x_q;
			pix_y_q <= cur_y_q;
			last_q  <= count_q == {{N{1'b0}}, 1'b1};
		end
	end

	assign pix_valid = pix_valid_q;
	assign pixel_x   = pix_x_q;
	assign pixel_y   = pix_y_q;
	assign last      = last_q;

endmodule
